@@ hdl/fpfa_pkg.sv @@
// Shared types and codes for the fixed-partition fit allocator.
package fpfa_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    localparam logic [0:0] CFG_FIT_MODE = 1'd0;
    localparam logic [0:0] CFG_PARTS    = 1'd1;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_DATA_W = 5;

    // operations issued to the partition table in one cycle
    typedef struct packed {
        logic load_en;
        logic clear_all;
        logic rd_en;
        logic mark_en;
    } t_tbl_ctrl;

endpackage

@@ hdl/fpfa_table.sv @@
// Partition table: size memory with registered read, and the taken flags.
module fpfa_table #(
    parameter int MAX_SLOTS = 16,
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fpfa_pkg::t_tbl_ctrl   i_ctrl,
    input  logic [IDX_W-1:0]      i_wr_idx,
    input  logic [SIZE_BITS-1:0]  i_wr_size,
    input  logic [IDX_W-1:0]      i_rd_idx,
    input  logic [IDX_W-1:0]      i_mark_idx,
    output logic [SIZE_BITS-1:0]  o_rd_size,
    output logic                  o_rd_taken
);

    logic [SIZE_BITS-1:0] r_size_mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_taken;
    logic [SIZE_BITS-1:0] r_rd_size;
    logic                 r_rd_taken;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_en) begin
            r_size_mem[i_wr_idx] <= i_wr_size;
        end
        if (i_ctrl.rd_en) begin
            r_rd_size <= r_size_mem[i_rd_idx];
        end
    end

    // loads, clears and marks never coincide with the scan reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken    <= '0;
            r_rd_taken <= 1'b0;
        end else begin
            if (i_ctrl.clear_all) begin
                r_taken <= '0;
            end else if (i_ctrl.load_en) begin
                r_taken[i_wr_idx] <= 1'b0;
            end else if (i_ctrl.mark_en) begin
                r_taken[i_mark_idx] <= 1'b1;
            end
            if (i_ctrl.rd_en) begin
                r_rd_taken <= r_taken[i_rd_idx];
            end
        end
    end

    assign o_rd_size  = r_rd_size;
    assign o_rd_taken = r_rd_taken;

    a_mark_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.mark_en |=> r_taken[$past(i_mark_idx)])
        else $error("granted partition not marked taken");

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear_all |=> (r_taken == '0))
        else $error("clear left a partition taken");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({i_ctrl.load_en, i_ctrl.clear_all, i_ctrl.mark_en}) <= 1)
        else $error("conflicting table updates");

endmodule

@@ hdl/fixed_partition_fit_allocator.sv @@
// Fixed-partition allocator with first, best and worst fit placement.
// Every input word gives exactly one result word. A load, clear or unused word
// goes straight to ST_FINISH, where its result is registered once the output
// register is free. An allocate word walks the searched partitions (partitions_in_use,
// capped at MAX_SLOTS) through the single read port of the size memory, one
// partition per cycle, then waits for the last read to return and for the read valid
// to fall; ST_FINISH then marks the grant and builds the result once the output
// register is free. The result sits in an output register, so the next word is
// taken while a finished result waits. Configuration must be written by the user
// only while the block is idle; the block itself does not enforce it.
module fixed_partition_fit_allocator #(
    parameter int MAX_SLOTS = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [0:0]                        i_cfg_addr,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // request stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [fpfa_pkg::IN_DATA_W-1:0]    i_s_tdata,  // slot_index[3:0], amount[19:4]
    input  logic [1:0]                        i_s_tuser,  // req_type[1:0]
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [fpfa_pkg::OUT_DATA_W-1:0]   o_m_tdata,  // chosen_slot[3:0],
                                                          // chosen_size[19:4], leftover[35:20]
    output logic                              o_m_tuser   // granted
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    fpfa_pkg::t_state r_state, n_state;

    logic [1:0]           r_fit_mode;
    logic [4:0]           r_parts;
    logic [SIZE_BITS-1:0] r_req, n_req;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_issue, n_issue;
    logic                 r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx, n_rd_idx;
    logic                 r_pick_vld, n_pick_vld;
    logic [IDX_W-1:0]     r_pick_idx, n_pick_idx;
    logic [SIZE_BITS-1:0] r_pick_size, n_pick_size;
    logic                 r_out_vld, n_out_vld;
    logic [fpfa_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic                 r_out_grant, n_out_grant;

    fpfa_pkg::t_tbl_ctrl  tbl_ctrl;
    logic [IDX_W-1:0]     rd_addr;
    logic [SIZE_BITS-1:0] rd_size;
    logic                 rd_taken;

    logic [1:0]           in_type;
    logic [3:0]           in_slot;
    logic [15:0]          in_amount;
    logic                 in_acc;
    logic                 load_ok;
    logic                 fits;
    logic                 take;
    logic                 out_free;
    logic [SIZE_BITS-1:0] rest;

    assign in_type   = i_s_tuser;
    assign in_slot   = i_s_tdata[3:0];
    assign in_amount = i_s_tdata[19:4];
    assign o_s_tready = (r_state == fpfa_pkg::ST_IDLE);
    assign in_acc    = i_s_tvalid && o_s_tready;
    assign load_ok   = (32'(in_slot) < 32'(MAX_SLOTS));
    assign out_free  = !r_out_vld || i_m_tready;
    assign rd_addr   = r_issue[IDX_W-1:0];
    assign rest      = r_pick_size - r_req;

    // candidate test on the word returned by the memory
    always_comb begin
        fits = r_rd_vld && !rd_taken && (rd_size >= r_req);
        case (r_fit_mode)
            fpfa_pkg::MODE_FIRST: take = fits && !r_pick_vld;
            fpfa_pkg::MODE_BEST:  take = fits && (!r_pick_vld || rd_size <= r_pick_size);
            fpfa_pkg::MODE_WORST: take = fits && (!r_pick_vld || rd_size >= r_pick_size);
            default:              take = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_count     = r_count;
        n_issue     = r_issue;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_pick_vld  = r_pick_vld;
        n_pick_idx  = r_pick_idx;
        n_pick_size = r_pick_size;
        n_out_vld   = r_out_vld && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_grant = r_out_grant;
        tbl_ctrl    = '0;

        unique case (r_state)
            fpfa_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_req      = SIZE_BITS'(in_amount);
                    n_issue    = '0;
                    n_pick_vld = 1'b0;
                    n_count    = (32'(r_parts) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                                : CNT_W'(r_parts);
                    tbl_ctrl.load_en   = (in_type == fpfa_pkg::REQ_LOAD) && load_ok;
                    tbl_ctrl.clear_all = (in_type == fpfa_pkg::REQ_CLEAR);
                    n_state = (in_type == fpfa_pkg::REQ_ALLOC) ? fpfa_pkg::ST_SCAN
                                                               : fpfa_pkg::ST_FINISH;
                end
            end
            fpfa_pkg::ST_SCAN: begin
                if (r_issue < r_count) begin
                    tbl_ctrl.rd_en = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = rd_addr;
                    n_issue  = r_issue + 1'b1;
                end else if (!r_rd_vld) begin
                    n_state = fpfa_pkg::ST_FINISH;
                end
                if (take) begin
                    n_pick_vld  = 1'b1;
                    n_pick_idx  = r_rd_idx;
                    n_pick_size = rd_size;
                end
            end
            fpfa_pkg::ST_FINISH: begin
                if (out_free) begin
                    tbl_ctrl.mark_en = r_pick_vld;
                    n_out_vld   = 1'b1;
                    n_out_grant = r_pick_vld;
                    n_out_data  = '0;
                    if (r_pick_vld) begin
                        n_out_data[3:0]   = 4'(r_pick_idx);
                        n_out_data[19:4]  = 16'(r_pick_size);
                        n_out_data[35:20] = 16'(rest);
                    end
                    n_state = fpfa_pkg::ST_IDLE;
                end
            end
            default: n_state = fpfa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fpfa_pkg::ST_IDLE;
            r_fit_mode <= fpfa_pkg::MODE_FIRST;
            r_parts    <= '0;
            r_rd_vld   <= 1'b0;
            r_pick_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_issue    <= '0;
            r_count    <= '0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= n_rd_vld;
            r_pick_vld <= n_pick_vld;
            r_out_vld  <= n_out_vld;
            r_issue    <= n_issue;
            r_count    <= n_count;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    fpfa_pkg::CFG_FIT_MODE: r_fit_mode <= i_cfg_wdata[1:0];
                    fpfa_pkg::CFG_PARTS:    r_parts    <= i_cfg_wdata;
                    default:                r_parts    <= r_parts;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_rd_idx    <= n_rd_idx;
        r_pick_idx  <= n_pick_idx;
        r_pick_size <= n_pick_size;
        r_out_data  <= n_out_data;
        r_out_grant <= n_out_grant;
    end

    fpfa_table #(
        .MAX_SLOTS (MAX_SLOTS),
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (tbl_ctrl),
        .i_wr_idx   (IDX_W'(in_slot)),
        .i_wr_size  (SIZE_BITS'(in_amount)),
        .i_rd_idx   (rd_addr),
        .i_mark_idx (r_pick_idx),
        .o_rd_size  (rd_size),
        .o_rd_taken (rd_taken)
    );

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_grant;

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_grant) |-> (r_out_data == '0))
        else $error("refused result carries data");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpfa_pkg::ST_SCAN) |-> (r_issue <= r_count))
        else $error("scan ran past the search count");

    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpfa_pkg::ST_FINISH && r_pick_vld) |-> (CNT_W'(r_pick_idx) < r_count))
        else $error("pick outside searched partitions");

endmodule

@@ verif/fixed_partition_fit_allocator_tb.sv @@
// Self-checking testbench for the fixed-partition fit allocator: directed and random words.
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_tb;

    localparam int          SLOTS       = 16;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam logic [1:0]  REQ_NONE    = 2'd3;
    localparam int          N_PHASES    = 29;
    localparam int          PHASE_WORDS = 50;
    localparam int          SETTLE      = 40;
    localparam int          STALL_LIMIT = 3000;

    typedef struct packed {
        logic        granted;
        logic [3:0]  slot;
        logic [15:0] size;
        logic [15:0] leftover;
    } t_alloc_grant;

    // Partition table model plus the queue of result words still owed by the block.
    class alloc_scoreboard;
        logic [1:0]   fit_mode;
        logic [4:0]   search_count;
        logic [15:0]  part_size [SLOTS];
        bit           part_taken[SLOTS];
        t_alloc_grant owed_q[$];
        int           errors;

        function new();
            fit_mode     = fpfa_pkg::MODE_FIRST;
            search_count = '0;
            errors       = 0;
            foreach (part_size[i]) begin
                part_size[i]  = '0;
                part_taken[i] = 1'b0;
            end
        endfunction

        function void set_reg(logic [0:0] idx, logic [4:0] val);
            if (idx == fpfa_pkg::CFG_FIT_MODE) begin
                fit_mode = val[1:0];
            end else begin
                search_count = val;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void note_request(logic [1:0] kind, logic [3:0] idx, logic [15:0] amt);
            t_alloc_grant res;
            int           n;
            int           pick;
            logic [15:0]  pick_size;
            res = '0;
            case (kind)
                fpfa_pkg::REQ_LOAD: begin
                    part_size[idx]  = amt;
                    part_taken[idx] = 1'b0;
                end
                fpfa_pkg::REQ_ALLOC: begin
                    n         = (search_count > SLOTS) ? SLOTS : int'(search_count);
                    pick      = -1;
                    pick_size = '0;
                    if (fit_mode != MODE_UNUSED) begin
                        for (int k = 0; k < n; k++) begin
                            if (!part_taken[k] && part_size[k] >= amt) begin
                                if (fit_mode == fpfa_pkg::MODE_FIRST) begin
                                    if (pick < 0) pick = k;
                                end else if (pick < 0
                                        || (fit_mode == fpfa_pkg::MODE_BEST
                                            && part_size[k] <= pick_size)
                                        || (fit_mode == fpfa_pkg::MODE_WORST
                                            && part_size[k] >= pick_size)) begin
                                    // ties go to the higher index
                                    pick      = k;
                                    pick_size = part_size[k];
                                end
                            end
                        end
                    end
                    if (pick >= 0) begin
                        part_taken[pick] = 1'b1;
                        res.granted  = 1'b1;
                        res.slot     = pick[3:0];
                        res.size     = part_size[pick];
                        res.leftover = part_size[pick] - amt;
                    end
                end
                fpfa_pkg::REQ_CLEAR: begin
                    foreach (part_taken[i]) part_taken[i] = 1'b0;
                end
                default: begin
                end
            endcase
            owed_q.push_back(res);
        endfunction

        function void check_grant(t_alloc_grant got);
            t_alloc_grant exp;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result word granted=%0b slot=%0d size=%0d left=%0d",
                         $time, got.granted, got.slot, got.size, got.leftover);
                errors++;
            end else begin
                exp = owed_q.pop_front();
                if (got.granted !== exp.granted) begin
                    $display("%0t: granted expected %0b actual %0b",
                             $time, exp.granted, got.granted);
                    errors++;
                end
                if (got.slot !== exp.slot) begin
                    $display("%0t: chosen_slot expected %0d actual %0d",
                             $time, exp.slot, got.slot);
                    errors++;
                end
                if (got.size !== exp.size) begin
                    $display("%0t: chosen_size expected %0d actual %0d",
                             $time, exp.size, got.size);
                    errors++;
                end
                if (got.leftover !== exp.leftover) begin
                    $display("%0t: leftover expected %0d actual %0d",
                             $time, exp.leftover, got.leftover);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_wr_en;
    logic [0:0]                        i_cfg_addr;
    logic [fpfa_pkg::CFG_DATA_W-1:0]   i_cfg_wdata;
    logic                              i_s_tvalid;
    logic                              o_s_tready;
    logic [fpfa_pkg::IN_DATA_W-1:0]    i_s_tdata;
    logic [1:0]                        i_s_tuser;
    logic                              o_m_tvalid;
    logic                              i_m_tready;
    logic [fpfa_pkg::OUT_DATA_W-1:0]   o_m_tdata;
    logic                              o_m_tuser;

    alloc_scoreboard sb;
    int              quiet_cycles = 0;
    bit              send_burst;
    t_alloc_grant    seen;

    logic [15:0] dir_sizes [SLOTS] = '{16'd0, 16'hFFFF, 16'd100, 16'd100, 16'd50, 16'h8000,
                                       16'h7FFF, 16'd1, 16'd2, 16'd300, 16'd300, 16'h5555,
                                       16'hAAAA, 16'd64, 16'd64, 16'd1000};

    fixed_partition_fit_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_amount();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            4:       return 16'(16 << $urandom_range(0, 2));
            default: return 16'($urandom_range(0, 1023));
        endcase
    endfunction

    // Both sides sampled at the clock edge, before any of this edge's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                seen.granted  = o_m_tuser;
                seen.slot     = o_m_tdata[3:0];
                seen.size     = o_m_tdata[19:4];
                seen.leftover = o_m_tdata[35:20];
                sb.check_grant(seen);
            end
            if (i_s_tvalid && o_s_tready) begin
                sb.note_request(i_s_tuser, i_s_tdata[3:0], i_s_tdata[19:4]);
            end
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
        end
    end

    initial begin
        @(posedge i_clk);
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    // result side back-pressure
    initial begin
        int gap;
        int hold;
        i_m_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            hold = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 8);
            repeat (hold) @(posedge i_clk);
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [4:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_word(logic [1:0] kind, logic [3:0] idx, logic [15:0] amt);
        int gap;
        gap = send_burst ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {4'b0000, amt, idx};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // drop valid and let every owed word come back before touching the registers
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_mode_and_count(logic [1:0] mode, logic [4:0] count);
        if ($urandom_range(0, 1)) begin
            write_reg(fpfa_pkg::CFG_FIT_MODE, {3'b000, mode});
            write_reg(fpfa_pkg::CFG_PARTS, count);
        end else begin
            write_reg(fpfa_pkg::CFG_PARTS, count);
            write_reg(fpfa_pkg::CFG_FIT_MODE, {3'b000, mode});
        end
    endtask

    initial begin
        logic [1:0] mode;
        logic [4:0] count;
        logic [1:0] kind;
        int         r;
        sb          = new();
        send_burst  = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = fpfa_pkg::REQ_LOAD;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fill the whole table before any search can read it
        set_mode_and_count(fpfa_pkg::MODE_FIRST, 5'd16);
        for (int i = 0; i < SLOTS; i++) begin
            send_word(fpfa_pkg::REQ_LOAD, 4'(i), dir_sizes[i]);
        end
        send_word(fpfa_pkg::REQ_ALLOC, 4'd0, 16'd0);      // zero request on a zero-size partition
        send_word(fpfa_pkg::REQ_ALLOC, 4'd0, 16'hFFFF);   // exact fit at the top size
        send_word(fpfa_pkg::REQ_ALLOC, 4'd0, 16'd100);
        send_word(fpfa_pkg::REQ_ALLOC, 4'd0, 16'hFFFF);   // nothing left that fits
        send_word(REQ_NONE, 4'hF, 16'hFFFF);
        send_word(fpfa_pkg::REQ_CLEAR, 4'd0, 16'd0);
        send_word(fpfa_pkg::REQ_LOAD, 4'd3, 16'd0);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin mode = fpfa_pkg::MODE_FIRST; count = 5'd0;  end
                1: begin mode = MODE_UNUSED;          count = 5'd16; end
                2: begin mode = fpfa_pkg::MODE_BEST;  count = 5'd16; end
                3: begin mode = fpfa_pkg::MODE_WORST; count = 5'd16; end
                4: begin mode = fpfa_pkg::MODE_BEST;  count = 5'd31; end
                5: begin mode = fpfa_pkg::MODE_WORST; count = 5'd1;  end
                6: begin mode = fpfa_pkg::MODE_FIRST; count = 5'd17; end
                default: begin
                    r = $urandom_range(0, 9);
                    mode = (r < 3) ? fpfa_pkg::MODE_FIRST : (r < 6) ? fpfa_pkg::MODE_BEST
                         : (r < 9) ? fpfa_pkg::MODE_WORST : MODE_UNUSED;
                    r = $urandom_range(0, 9);
                    count = (r == 0) ? 5'd0 : (r == 1) ? 5'($urandom_range(17, 31))
                          : (r == 2) ? 5'd16 : 5'($urandom_range(1, 16));
                end
            endcase
            set_mode_and_count(mode, count);
            send_burst = ($urandom_range(0, 4) == 0);
            for (int w = 0; w < PHASE_WORDS; w++) begin
                r = $urandom_range(0, 99);
                kind = (r < 55) ? fpfa_pkg::REQ_ALLOC : (r < 83) ? fpfa_pkg::REQ_LOAD
                     : (r < 91) ? fpfa_pkg::REQ_CLEAR : REQ_NONE;
                send_word(kind, 4'($urandom_range(0, 15)), pick_amount());
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
